[hdl/rsdz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared types and constants for the radial stick dead zone core.
// ----------------------------------------------------------------------------
package rsdz_pkg;

	localparam int SQRT_STEPS  = 16;
	localparam int REMAP_STEPS = 14;
	localparam int AXIS_STEPS  = 15;

	// pipeline stage numbers, counted from the accepting edge
	localparam int STG_SUM  = 2;
	localparam int STG_POST = STG_SUM + SQRT_STEPS + 1;
	localparam int STG_MUL  = STG_POST + REMAP_STEPS + 1;
	localparam int STG_LAST = STG_MUL + AXIS_STEPS;
	localparam int LATENCY  = STG_LAST + 1;

	localparam logic [14:0] FULL_SCALE = 15'd16384;

	localparam logic [1:0] REG_INNER = 2'd0;
	localparam logic [1:0] REG_OUTER = 2'd1;

	typedef struct packed {
		logic [31:0] sum;
		logic [16:0] rem;
		logic [15:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [15:0] dvs;
		logic [14:0] feed;
		logic [14:0] quo;
	} div_t;

	typedef struct packed {
		logic        neg_x;
		logic        neg_y;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] mag;
		logic        dead;
		logic        sat;
	} meta_t;

endpackage

[hdl/rsdz_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_sqrt_cell
// One digit of a restoring integer square root; registered hand-off.
// ----------------------------------------------------------------------------
module rsdz_sqrt_cell
	import rsdz_pkg::*;
(
	input  logic  clk,
	input  sqrt_t d,
	output sqrt_t q
);

	logic [18:0] r2;
	logic [18:0] trial;
	logic        ge;
	logic [18:0] sub;

	always_comb begin
		r2    = {d.rem, d.sum[31:30]};
		trial = {1'b0, d.root, 2'b01};
		ge    = (r2 >= trial);
		sub   = r2 - trial;
	end

	always_ff @(posedge clk) begin
		q.sum  <= {d.sum[29:0], 2'b00};
		q.rem  <= ge ? sub[16:0] : r2[16:0];
		q.root <= {d.root[14:0], ge};
	end

endmodule

[hdl/rsdz_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_div_cell
// One quotient bit of a restoring divider; registered hand-off.
// ----------------------------------------------------------------------------
module rsdz_div_cell
	import rsdz_pkg::*;
(
	input  logic clk,
	input  div_t d,
	output div_t q
);

	logic [16:0] r2;
	logic        ge;

	always_comb begin
		r2 = {d.rem[15:0], d.feed[14]};
		ge = (r2 >= {1'b0, d.dvs});
	end

	always_ff @(posedge clk) begin
		q.rem  <= ge ? (r2 - {1'b0, d.dvs}) : r2;
		q.dvs  <= d.dvs;
		q.feed <= {d.feed[13:0], 1'b0};
		q.quo  <= {d.quo[13:0], ge};
	end

endmodule

[hdl/radial_stick_dead_zone_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_stick_dead_zone_core
// Scaled radial dead zone for signed Q2.14 stick samples.
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge with start high (busy stays low), and
// its conditioned word appears on out_x/out_y with out_valid high exactly 50
// cycles later, for one cycle only: the receiver must take it then. One word
// leaves per word taken, in order. The latency is set by the chain of
// bit cells: 16 square-root cells, 14 cells for the remap divide and 15 cells
// for the per-axis divide, plus squaring, summing, zone compare, product and
// output registers. Write inner_zone (index 0) and outer_zone (index 1) only
// while no sample is in flight; cfg_ready is always high and other indexes
// are dropped.
// ----------------------------------------------------------------------------
module radial_stick_dead_zone_core
	import rsdz_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] stick_x,
	input  logic signed [15:0] stick_y,
	output logic               out_valid,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [12:0] inner_q;
	logic [12:0] outer_q;

	logic [STG_LAST:1] vld_q;
	meta_t             meta_q [1:STG_LAST];

	logic [31:0] sqx_s1;
	logic [31:0] sqy_s1;

	sqrt_t sq_q [0:SQRT_STEPS];
	div_t  rm_q [0:REMAP_STEPS];
	div_t  axx_q [0:AXIS_STEPS];
	div_t  axy_q [0:AXIS_STEPS];

	logic [15:0] in_ax;
	logic [15:0] in_ay;
	logic [15:0] mag;
	logic [15:0] diff;
	logic [14:0] divisor;
	logic [14:0] remap;
	logic [30:0] px;
	logic [30:0] py;

	logic               out_valid_q;
	logic signed [15:0] out_x_q;
	logic signed [15:0] out_y_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// zone registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= 13'd1638;
			outer_q <= 13'd0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_INNER) begin
				inner_q <= cfg_data[12:0];
			end
			if (cfg_index == REG_OUTER) begin
				outer_q <= cfg_data[12:0];
			end
		end
	end

	// valid travels alongside the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_q       <= {vld_q[STG_LAST-1:1], start};
			out_valid_q <= vld_q[STG_LAST];
		end
	end

	// absolute values; -32768 folds to 32768 which fits 16 unsigned bits
	always_comb begin
		in_ax = stick_x[15] ? 16'(-stick_x) : stick_x;
		in_ay = stick_y[15] ? 16'(-stick_y) : stick_y;
	end

	// post-root arithmetic: magnitude, offset and divisor
	always_comb begin
		mag     = sq_q[SQRT_STEPS].root;
		diff    = mag - {3'b000, inner_q};
		divisor = FULL_SCALE - {2'b00, inner_q} - {2'b00, outer_q};
	end

	// remap saturates at full scale once the offset reaches the divisor; also the axis products
	always_comb begin
		remap = meta_q[STG_MUL-1].sat ? FULL_SCALE
			: {1'b0, rm_q[REMAP_STEPS].quo[13:0]};
		px    = meta_q[STG_MUL-1].ax * remap;
		py    = meta_q[STG_MUL-1].ay * remap;
	end

	always_ff @(posedge clk) begin
		// squares and their sum
		sqx_s1 <= in_ax * in_ax;
		sqy_s1 <= in_ay * in_ay;
		sq_q[0].sum  <= sqx_s1 + sqy_s1;
		sq_q[0].rem  <= '0;
		sq_q[0].root <= '0;

		// side data; a later stage fills in magnitude and flags
		meta_q[1].neg_x <= stick_x[15];
		meta_q[1].neg_y <= stick_y[15];
		meta_q[1].ax    <= in_ax;
		meta_q[1].ay    <= in_ay;
		meta_q[1].mag   <= '0;
		meta_q[1].dead  <= 1'b0;
		meta_q[1].sat   <= 1'b0;
		for (int i = 2; i <= STG_LAST; i++) begin
			if (i != STG_POST) begin
				meta_q[i] <= meta_q[i-1];
			end
		end
		meta_q[STG_POST].neg_x <= meta_q[STG_POST-1].neg_x;
		meta_q[STG_POST].neg_y <= meta_q[STG_POST-1].neg_y;
		meta_q[STG_POST].ax    <= meta_q[STG_POST-1].ax;
		meta_q[STG_POST].ay    <= meta_q[STG_POST-1].ay;
		meta_q[STG_POST].mag   <= mag;
		meta_q[STG_POST].dead  <= (mag <= {3'b000, inner_q});
		meta_q[STG_POST].sat   <= (diff >= {1'b0, divisor});

		// remap divide: shift in zeros; quotient used only when offset is below divisor
		rm_q[0].rem  <= {1'b0, diff};
		rm_q[0].dvs  <= {1'b0, divisor};
		rm_q[0].feed <= '0;
		rm_q[0].quo  <= '0;

		// axis divide: the upper product half is below the magnitude
		axx_q[0].rem  <= {2'b00, px[29:15]};
		axx_q[0].dvs  <= meta_q[STG_MUL-1].mag;
		axx_q[0].feed <= px[14:0];
		axx_q[0].quo  <= '0;
		axy_q[0].rem  <= {2'b00, py[29:15]};
		axy_q[0].dvs  <= meta_q[STG_MUL-1].mag;
		axy_q[0].feed <= py[14:0];
		axy_q[0].quo  <= '0;

		// restore signs, drop everything inside the dead zone
		if (meta_q[STG_LAST].dead) begin
			out_x_q <= '0;
			out_y_q <= '0;
		end else begin
			out_x_q <= meta_q[STG_LAST].neg_x ? 16'(-{1'b0, axx_q[AXIS_STEPS].quo})
				: {1'b0, axx_q[AXIS_STEPS].quo};
			out_y_q <= meta_q[STG_LAST].neg_y ? 16'(-{1'b0, axy_q[AXIS_STEPS].quo})
				: {1'b0, axy_q[AXIS_STEPS].quo};
		end
	end

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		rsdz_sqrt_cell u_cell (.clk(clk), .d(sq_q[g]), .q(sq_q[g+1]));
	end

	for (genvar g = 0; g < REMAP_STEPS; g++) begin : g_remap
		rsdz_div_cell u_cell (.clk(clk), .d(rm_q[g]), .q(rm_q[g+1]));
	end

	for (genvar g = 0; g < AXIS_STEPS; g++) begin : g_axis
		rsdz_div_cell u_cell_x (.clk(clk), .d(axx_q[g]), .q(axx_q[g+1]));
		rsdz_div_cell u_cell_y (.clk(clk), .d(axy_q[g]), .q(axy_q[g+1]));
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

endmodule

[hdl/rsdz_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_checker
// Port-level checks for the radial stick dead zone core.
// ----------------------------------------------------------------------------
module rsdz_checker
	import rsdz_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [15:0] stick_x,
	input logic signed [15:0] stick_y,
	input logic               out_valid,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y
);

	logic [5:0] warm_q;
	logic       warm;

	assign warm = (warm_q == 6'(LATENCY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (!warm) begin
			warm_q <= warm_q + 6'd1;
		end
	end

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_one_per_word: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (out_valid == $past(start && !busy, LATENCY)))
		else $error("result strobe does not match accepted word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_x <= 16'sd16384 && out_x >= -16'sd16384
			&& out_y <= 16'sd16384 && out_y >= -16'sd16384))
		else $error("result beyond full scale");

	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && out_valid && $past(stick_x == 16'sd0 && stick_y == 16'sd0, LATENCY))
		|-> (out_x == 16'sd0 && out_y == 16'sd0))
		else $error("centred stick gave non-zero result");

endmodule

bind radial_stick_dead_zone_core rsdz_checker u_rsdz_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.stick_x(stick_x), .stick_y(stick_y),
	.out_valid(out_valid), .out_x(out_x), .out_y(out_y)
);
